[rtl/core/baft_pkg.sv]
`default_nettype none

package baft_pkg;

  localparam int CODE_W = 16;
  localparam int PERIOD_W = 8;
  localparam int IN_USE_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MASK_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_USE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE0 = 3'd2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd4;

  localparam logic [1:0] REQ_KEY = 2'd0;
  localparam logic [1:0] REQ_MASK = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [CODE_W-1:0] key_code;
    logic              pressed;
    logic [MASK_W-1:0] enable_mask;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic              matched;
    logic [CODE_W-1:0] event_code;
    logic              event_down;
    logic              last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [IN_USE_W-1:0] in_use;
  } cfg_t;

  typedef struct packed {
    logic                ten;
    logic                held;
    logic                vp;
    logic [PERIOD_W-1:0] fc;
    logic                twa;
    logic                lvl;
  } ent_t;

endpackage

`default_nettype wire

[rtl/core/baft_ram.sv]
`default_nettype none

module baft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/baft_cfg.sv]
`default_nettype none

module baft_cfg
  import baft_pkg::*;
#(
  parameter int NUM_BINDINGS = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]                cfg_index,
  input  wire logic [CFG_DATA_W-1:0]               cfg_data,
  output cfg_t                                     cfg_s,
  output logic      [NUM_BINDINGS-1:0][CODE_W-1:0] codes
);

  cfg_t                            cfg_r;
  logic [NUM_BINDINGS-1:0][CODE_W-1:0] codes_r;

  assign cfg_ready = 1'b1;
  assign cfg_s = cfg_r;
  assign codes = codes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period <= PERIOD_RESET;
      cfg_r.in_use <= '0;
      codes_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_PERIOD) begin
        cfg_r.period <= cfg_data[PERIOD_W-1:0];
      end
      if (cfg_index == REG_IN_USE) begin
        cfg_r.in_use <= cfg_data[IN_USE_W-1:0];
      end
      for (int i = 0; i < NUM_BINDINGS; i++) begin
        if (cfg_index == REG_CODE0 + CFG_IDX_W'(i)) begin
          codes_r[i] <= cfg_data[CODE_W-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/baft_seq.sv]
`default_nettype none

module baft_seq
  import baft_pkg::*;
#(
  parameter int NUM_BINDINGS = 4,
  localparam int IDX_W = (NUM_BINDINGS > 1) ? $clog2(NUM_BINDINGS) : 1,
  localparam int CNT_W = $clog2(NUM_BINDINGS + 1)
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire in_item_t                            in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output out_item_t                                out_data,
  input  wire cfg_t                                cfg_s,
  input  wire logic [NUM_BINDINGS-1:0][CODE_W-1:0] codes,
  output logic                                     ram_re,
  output logic      [IDX_W-1:0]                    ram_raddr,
  input  wire ent_t                                ram_rdata,
  output logic                                     ram_we,
  output logic      [IDX_W-1:0]                    ram_waddr,
  output ent_t                                     ram_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_MOD,
    S_FLUSH
  } state_t;

  state_t                  state_r;
  in_item_t                item_r;
  logic [IDX_W-1:0]        cnt_r;
  logic                    pend_valid_r;
  out_item_t               pend_r;
  logic                    out_valid_r;
  out_item_t               out_r;
  logic [NUM_BINDINGS-1:0] vld_r;
  logic                    rvld_r;

  logic [CNT_W-1:0] n;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  ent_t             cur;
  ent_t             ent_nxt;
  logic             want;
  logic             evt;
  logic             out_free;
  logic             hold;
  logic             last_ent;
  logic             out_load;
  out_item_t        evt_item;
  out_item_t        reply_item;
  out_item_t        flush_item;

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (cfg_s.in_use > IN_USE_W'(NUM_BINDINGS)) begin
      n = CNT_W'(NUM_BINDINGS);
    end else begin
      n = CNT_W'(cfg_s.in_use);
    end
  end

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    for (int i = NUM_BINDINGS - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < n) && (codes[i] == in_data.key_code)) begin
        hit = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    reply_item.result_kind = KIND_REPLY;
    reply_item.matched = hit;
    reply_item.event_code = '0;
    reply_item.event_down = 1'b0;
    reply_item.last_of_run = 1'b0;
  end

  always_comb begin
    cur = rvld_r ? ram_rdata : '0;
    ent_nxt = cur;
    want = cur.held;
    evt = 1'b0;
    case (item_r.req_type)
      REQ_KEY: begin
        ent_nxt.held = item_r.pressed;
        if (!item_r.pressed && cur.held) begin
          ent_nxt.vp = 1'b0;
          ent_nxt.fc = '0;
          ent_nxt.twa = 1'b0;
        end
      end
      REQ_MASK: begin
        ent_nxt.ten = item_r.enable_mask[cnt_r];
        if (cur.ten && !item_r.enable_mask[cnt_r]) begin
          ent_nxt.vp = 1'b0;
          ent_nxt.fc = '0;
          ent_nxt.twa = 1'b0;
        end
      end
      REQ_TICK: begin
        if (!(cur.ten && cur.held)) begin
          ent_nxt.twa = 1'b0;
        end else begin
          if (!cur.twa && !cur.vp) begin
            ent_nxt.vp = 1'b1;
            ent_nxt.fc = '0;
          end
          ent_nxt.fc = ent_nxt.fc + PERIOD_W'(1);
          if (ent_nxt.fc >= cfg_s.period) begin
            ent_nxt.vp = ~ent_nxt.vp;
            ent_nxt.fc = '0;
          end
          want = ent_nxt.vp;
          ent_nxt.twa = 1'b1;
        end
        if (want != cur.lvl) begin
          evt = 1'b1;
          ent_nxt.lvl = want;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    evt_item.result_kind = KIND_EVENT;
    evt_item.matched = 1'b0;
    evt_item.event_code = codes[cnt_r];
    evt_item.event_down = want;
    evt_item.last_of_run = 1'b0;
  end

  always_comb begin
    flush_item = pend_r;
    flush_item.last_of_run = 1'b1;
  end

  assign hold = evt && pend_valid_r && !out_free;
  assign last_ent = ((CNT_W'(cnt_r) + CNT_W'(1)) == n) || (item_r.req_type == REQ_KEY);
  assign out_load = ((state_r == S_MOD) && !hold && evt && pend_valid_r) ||
                    ((state_r == S_FLUSH) && pend_valid_r && out_free);

  assign ram_re = (state_r == S_RD);
  assign ram_raddr = cnt_r;
  assign ram_we = (state_r == S_MOD) && !hold;
  assign ram_waddr = cnt_r;
  assign ram_wdata = ent_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
            case (in_data.req_type)
              REQ_KEY: begin
                pend_r <= reply_item;
                pend_valid_r <= 1'b1;
                cnt_r <= hit_idx;
                state_r <= hit ? S_RD : S_FLUSH;
              end
              REQ_MASK, REQ_TICK: begin
                cnt_r <= '0;
                state_r <= (n == '0) ? S_FLUSH : S_RD;
              end
              default: begin
                cnt_r <= '0;
                state_r <= S_FLUSH;
              end
            endcase
          end
        end
        S_RD: begin
          rvld_r <= vld_r[cnt_r];
          state_r <= S_MOD;
        end
        S_MOD: begin
          if (!hold) begin
            vld_r[cnt_r] <= 1'b1;
            if (evt) begin
              if (pend_valid_r) begin
                out_r <= pend_r;
              end
              pend_r <= evt_item;
              pend_valid_r <= 1'b1;
            end
            if (last_ent) begin
              state_r <= S_FLUSH;
            end else begin
              cnt_r <= cnt_r + IDX_W'(1);
              state_r <= S_RD;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid_r) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_r <= flush_item;
            pend_valid_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/button_autofire_table_top.sv]
// Channel  Handshake              Payload      Moves
// in       in_valid / in_stall    in_data      one request item toward the table
// out      out_valid / out_stall  out_data     one reply or key event item
// cfg      cfg_valid / cfg_ready  cfg_index    one register write of cfg_data
//
// Items are handled one at a time; each entry visited is first read and then
// read-modify-written in the binding state memory.
// A press or release visits only the matching entry, or none on a miss; a mask update or
// frame tick visits the entry of each active binding in turn.
// Synchronous active-low reset clears the control state and the per-entry valid bits.
// A stalled result stream holds the walk when a second event or the last item must wait.
`default_nettype none

module button_autofire_table_top
  import baft_pkg::*;
#(
  parameter int NUM_BINDINGS = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (NUM_BINDINGS > 1) ? $clog2(NUM_BINDINGS) : 1;

  cfg_t                                cfg_s;
  logic [NUM_BINDINGS-1:0][CODE_W-1:0] codes;
  logic                                ram_re;
  logic [IDX_W-1:0]                    ram_raddr;
  ent_t                                ram_rdata;
  logic                                ram_we;
  logic [IDX_W-1:0]                    ram_waddr;
  ent_t                                ram_wdata;

  baft_cfg #(
    .NUM_BINDINGS(NUM_BINDINGS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg_s    (cfg_s),
    .codes    (codes)
  );

  baft_ram #(
    .WIDTH($bits(ent_t)),
    .DEPTH(NUM_BINDINGS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  baft_seq #(
    .NUM_BINDINGS(NUM_BINDINGS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_s    (cfg_s),
    .codes    (codes),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata)
  );

endmodule

`default_nettype wire

[rtl/core/baft_chk.sv]
`default_nettype none

module baft_chk
  import baft_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire out_item_t out_data,
  input wire logic      out_valid,
  input wire logic      out_stall
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result item changed or dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Block took a new item right after accepting one.");

  a_reply_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == KIND_REPLY) |->
      out_data.last_of_run && (out_data.event_code == '0) && !out_data.event_down)
    else $error("Reply item is not a single closing item with empty event fields.");

  a_event_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == KIND_EVENT) |-> !out_data.matched)
    else $error("Key event item carries a match flag.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result item present right after reset.");

endmodule

bind button_autofire_table_top baft_chk u_baft_chk (.*);

`default_nettype wire
